### design/mos_pkg.sv
package mos_pkg;

  localparam int WINDOW_DEPTH = 24;
  localparam int VAL_W = 16;
  localparam int FRAC_BITS = 6;
  localparam int LIMIT_W = 9;
  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = VAL_W + CNT_W;
  localparam int MAG_W = SUM_W - 1;
  localparam int STEP_W = $clog2(MAG_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [LIMIT_W-1:0] X_LIMIT_RESET = LIMIT_W'(5);
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RESET = LIMIT_W'(20);

  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [VAL_W-1:0] meas_dx;
    logic signed [VAL_W-1:0] meas_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] smooth_dx;
    logic signed [VAL_W-1:0] smooth_dy;
    logic                    rejected;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic accum;
    logic remove_old;
    logic step;
    logic finish;
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### design/mos_ram.sv
module mos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/mos_lane.sv
module mos_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  mos_pkg::lane_ctrl_t               ctrl,
  input  logic signed [mos_pkg::VAL_W-1:0]  meas,
  input  logic [mos_pkg::LIMIT_W-1:0]       limit,
  input  logic                              rej,
  input  logic signed [mos_pkg::VAL_W-1:0]  old_val,
  input  logic [mos_pkg::CNT_W-1:0]         divisor,
  output logic                              over,
  output logic signed [mos_pkg::VAL_W-1:0]  val,
  output logic signed [mos_pkg::VAL_W-1:0]  mean
);

  logic signed [mos_pkg::VAL_W-1:0] meas_r;
  logic signed [mos_pkg::VAL_W-1:0] last_mean;
  logic signed [mos_pkg::SUM_W-1:0] sum;
  logic signed [mos_pkg::SUM_W-1:0] sum_next;
  logic signed [mos_pkg::SUM_W-1:0] old_ext;
  logic signed [mos_pkg::SUM_W-1:0] val_ext;
  logic [mos_pkg::SUM_W-1:0]        sum_abs;
  logic [mos_pkg::VAL_W-1:0]        meas_abs;
  logic [mos_pkg::MAG_W-1:0]        work;
  logic [mos_pkg::CNT_W-1:0]        rem;
  logic [mos_pkg::CNT_W:0]          shifted;
  logic [mos_pkg::CNT_W:0]          diff;
  logic                             ge;
  logic                             neg;
  logic [mos_pkg::VAL_W-1:0]        quot;

  // Integer magnitude is |v| >> FRAC_BITS; the most negative code gives 512.
  assign meas_abs = meas_r[mos_pkg::VAL_W-1] ? (~meas_r + 1'b1) : meas_r;
  assign over = meas_abs[mos_pkg::VAL_W-1:mos_pkg::FRAC_BITS] > {1'b0, limit};
  assign val = rej ? last_mean : meas_r;

  assign old_ext = ctrl.remove_old ? mos_pkg::SUM_W'(old_val) : '0;
  assign val_ext = mos_pkg::SUM_W'(val);
  assign sum_next = sum - old_ext + val_ext;
  assign sum_abs = sum_next[mos_pkg::SUM_W-1] ? -sum_next : sum_next;

  // One restoring division step per cycle on the magnitude of the sum.
  assign shifted = {rem, work[mos_pkg::MAG_W-1]};
  assign diff = shifted - {1'b0, divisor};
  assign ge = shifted >= {1'b0, divisor};

  assign quot = work[mos_pkg::VAL_W-1:0];
  assign mean = neg ? -quot : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      last_mean <= '0;
    end else begin
      if (ctrl.accum) begin
        sum <= sum_next;
      end
      if (ctrl.finish) begin
        last_mean <= mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      meas_r <= meas;
    end
    if (ctrl.accum) begin
      work <= sum_abs[mos_pkg::MAG_W-1:0];
      rem <= '0;
      neg <= sum_next[mos_pkg::SUM_W-1];
    end else if (ctrl.step) begin
      work <= {work[mos_pkg::MAG_W-2:0], ge};
      rem <= ge ? diff[mos_pkg::CNT_W-1:0] : shifted[mos_pkg::CNT_W-1:0];
    end
  end

  // A window mean of 16-bit values always fits back into 16 bits.
  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> work <= mos_pkg::MAG_W'(32768))
    else $error("lane quotient exceeds the output range");

  // Remainder of a restoring step stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> rem < divisor)
    else $error("lane remainder not below divisor");

endmodule

### design/motion_offset_smoother.sv
// Motion offset smoother: keeps a running mean over the last 24 accepted
// (dx, dy) offsets in signed Q9.6, replacing outliers by the previous mean.
// Input channel in_valid/in_ready/in_data carries one measurement; output
// channel out_valid/out_ready/out_data returns one smoothed pair per
// measurement together with a rejected flag. The cfg channel writes the
// x limit (index 0) and y limit (index 1); cfg_ready is always high and
// other indexes are ignored. Write limits only while no item is in flight.
// Each item is processed in full before the next one is taken: the
// oldest window entry is read from the window RAM at acceptance, the sums
// are updated, a bit-serial restoring divider runs one step per magnitude
// bit of the sum in each of the two axis lanes, and the output register is
// loaded. in_ready rises again in the cycle after that load.
// Reset clears the sums, pointer, fill count and previous mean; the limits
// return to 5 and 20. When the receiver stalls, the result waits in the
// output register while the next item is processed; that item then waits
// until the output register is free before in_ready rises again.
module motion_offset_smoother (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mos_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mos_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mos_pkg::LIMIT_W-1:0]     cfg_data
);

  mos_pkg::state_t state;
  mos_pkg::state_t state_next;
  mos_pkg::lane_ctrl_t ctrl;

  logic [mos_pkg::LIMIT_W-1:0] x_limit;
  logic [mos_pkg::LIMIT_W-1:0] y_limit;
  logic [mos_pkg::PTR_W-1:0]   wp;
  logic [mos_pkg::CNT_W-1:0]   fill_count;
  logic [mos_pkg::STEP_W-1:0]  step_cnt;
  logic                        full;
  logic                        rej;
  logic                        rej_r;
  logic                        out_load;
  logic                        over_x;
  logic                        over_y;
  logic signed [mos_pkg::VAL_W-1:0] val_x;
  logic signed [mos_pkg::VAL_W-1:0] val_y;
  logic signed [mos_pkg::VAL_W-1:0] mean_x;
  logic signed [mos_pkg::VAL_W-1:0] mean_y;
  logic [2*mos_pkg::VAL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign full = fill_count == mos_pkg::CNT_W'(mos_pkg::WINDOW_DEPTH);
  assign rej = over_x | over_y;

  always_comb begin
    state_next = state;
    ctrl = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      mos_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next = mos_pkg::S_LOAD;
        end
      end
      mos_pkg::S_LOAD: begin
        ctrl.accum = 1'b1;
        ctrl.remove_old = full;
        state_next = mos_pkg::S_DIV;
      end
      mos_pkg::S_DIV: begin
        ctrl.step = 1'b1;
        if (step_cnt == mos_pkg::STEP_W'(mos_pkg::MAG_W - 1)) begin
          state_next = mos_pkg::S_DONE;
        end
      end
      mos_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          ctrl.finish = 1'b1;
          state_next = mos_pkg::S_IDLE;
        end
      end
      default: state_next = mos_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mos_pkg::S_IDLE;
      x_limit <= mos_pkg::X_LIMIT_RESET;
      y_limit <= mos_pkg::Y_LIMIT_RESET;
      wp <= '0;
      fill_count <= '0;
      step_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mos_pkg::REG_X_LIMIT) begin
          x_limit <= cfg_data;
        end else if (cfg_index == mos_pkg::REG_Y_LIMIT) begin
          y_limit <= cfg_data;
        end
      end
      if (ctrl.accum) begin
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
        if (wp == mos_pkg::PTR_W'(mos_pkg::WINDOW_DEPTH - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + 1'b1;
        end
        step_cnt <= '0;
      end else if (ctrl.step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accum) begin
      rej_r <= rej;
    end
    if (out_load) begin
      out_data.smooth_dx <= mean_x;
      out_data.smooth_dy <= mean_y;
      out_data.rejected <= rej_r;
    end
  end

  // The oldest entry is read at acceptance and replaced in the following cycle.
  mos_ram #(
    .WIDTH(2 * mos_pkg::VAL_W),
    .DEPTH(mos_pkg::WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .we   (ctrl.accum),
    .waddr(wp),
    .wdata({val_y, val_x}),
    .re   (ctrl.capture),
    .raddr(wp),
    .rdata(ram_rdata)
  );

  mos_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .meas   (in_data.meas_dx),
    .limit  (x_limit),
    .rej    (rej),
    .old_val(ram_rdata[mos_pkg::VAL_W-1:0]),
    .divisor(fill_count),
    .over   (over_x),
    .val    (val_x),
    .mean   (mean_x)
  );

  mos_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .meas   (in_data.meas_dy),
    .limit  (y_limit),
    .rej    (rej),
    .old_val(ram_rdata[2*mos_pkg::VAL_W-1:mos_pkg::VAL_W]),
    .divisor(fill_count),
    .over   (over_y),
    .val    (val_y),
    .mean   (mean_y)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= mos_pkg::CNT_W'(mos_pkg::WINDOW_DEPTH) &&
    wp < mos_pkg::PTR_W'(mos_pkg::WINDOW_DEPTH))
    else $error("window pointer or fill count out of range");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fill_count >= $past(fill_count))
    else $error("fill count decreased");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == mos_pkg::S_DONE)
    else $error("output raised outside the completion state");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> fill_count != '0)
    else $error("division started with an empty window");

endmodule

### test/tb_motion_offset_smoother.sv
`timescale 1ns / 100ps

module tb_motion_offset_smoother;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int MAX_PRINTED = 40;

  // Indexes that no register answers to; writes there must change nothing.
  localparam logic [mos_pkg::CFG_IDX_W-1:0] REG_SPARE_A = mos_pkg::CFG_IDX_W'(2);
  localparam logic [mos_pkg::CFG_IDX_W-1:0] REG_SPARE_B = mos_pkg::CFG_IDX_W'(3);

  typedef enum int {
    RDY_ALWAYS,
    RDY_SPARSE_STALL,
    RDY_LONG_STALL,
    RDY_COIN
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mos_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mos_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mos_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mos_pkg::LIMIT_W-1:0] cfg_data = '0;

  // Predicted block state.
  logic signed [mos_pkg::VAL_W-1:0] win_dx[mos_pkg::WINDOW_DEPTH];
  logic signed [mos_pkg::VAL_W-1:0] win_dy[mos_pkg::WINDOW_DEPTH];
  int win_ptr = 0;
  int win_fill = 0;
  int acc_x = 0;
  int acc_y = 0;
  logic signed [mos_pkg::VAL_W-1:0] prev_mean_x = '0;
  logic signed [mos_pkg::VAL_W-1:0] prev_mean_y = '0;
  logic [mos_pkg::LIMIT_W-1:0] lim_x = mos_pkg::X_LIMIT_RESET;
  logic [mos_pkg::LIMIT_W-1:0] lim_y = mos_pkg::Y_LIMIT_RESET;

  mos_pkg::out_item_t mean_queue[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int burst_left = 0;

  motion_offset_smoother i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, mean_queue.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Works out the smoothed pair for one accepted measurement and queues it.
  function automatic void smooth_offset(input logic signed [mos_pkg::VAL_W-1:0] dx,
                                        input logic signed [mos_pkg::VAL_W-1:0] dy);
    int vx;
    int vy;
    int mag_x;
    int mag_y;
    int qx;
    int qy;
    logic rej;
    mos_pkg::out_item_t r;
    vx = dx;
    vy = dy;
    mag_x = ((vx < 0) ? -vx : vx) >> mos_pkg::FRAC_BITS;
    mag_y = ((vy < 0) ? -vy : vy) >> mos_pkg::FRAC_BITS;
    rej = (mag_x > int'(lim_x)) || (mag_y > int'(lim_y));
    if (rej) begin
      vx = prev_mean_x;
      vy = prev_mean_y;
    end
    if (win_fill >= mos_pkg::WINDOW_DEPTH) begin
      acc_x = acc_x - int'(win_dx[win_ptr]);
      acc_y = acc_y - int'(win_dy[win_ptr]);
    end else begin
      win_fill++;
    end
    win_dx[win_ptr] = vx[mos_pkg::VAL_W-1:0];
    win_dy[win_ptr] = vy[mos_pkg::VAL_W-1:0];
    acc_x += vx;
    acc_y += vy;
    win_ptr = (win_ptr + 1) % mos_pkg::WINDOW_DEPTH;
    qx = acc_x / win_fill;
    qy = acc_y / win_fill;
    prev_mean_x = qx[mos_pkg::VAL_W-1:0];
    prev_mean_y = qy[mos_pkg::VAL_W-1:0];
    r.smooth_dx = qx[mos_pkg::VAL_W-1:0];
    r.smooth_dy = qy[mos_pkg::VAL_W-1:0];
    r.rejected = rej;
    mean_queue = {mean_queue, r};
  endfunction

  // Offset whose integer magnitude mostly sits inside or just past the limit.
  function automatic logic signed [mos_pkg::VAL_W-1:0] rand_offset(
      input logic [mos_pkg::LIMIT_W-1:0] lim);
    int kind;
    int top;
    int mag;
    kind = int'($urandom_range(0, 19));
    top = (int'(lim) + 1) * 64 - 1;
    if (top > 32767) top = 32767;
    if (kind < 10) begin
      mag = int'($urandom_range(0, top));
    end else if (kind < 14) begin
      mag = int'(lim) * 64 + int'($urandom_range(0, 127));
      if (mag > 32767) mag = 32767;
    end else if (kind < 19) begin
      return mos_pkg::VAL_W'($urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return -16'sd1;
        default: return '0;
      endcase
    end
    return ($urandom_range(0, 1) != 0) ? mos_pkg::VAL_W'(-mag) : mos_pkg::VAL_W'(mag);
  endfunction

  task automatic write_reg(input logic [mos_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mos_pkg::LIMIT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mos_pkg::REG_X_LIMIT: lim_x = val;
      mos_pkg::REG_Y_LIMIT: lim_y = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [mos_pkg::LIMIT_W-1:0] xl,
                            input logic [mos_pkg::LIMIT_W-1:0] yl);
    write_reg(mos_pkg::REG_X_LIMIT, xl);
    write_reg(mos_pkg::REG_Y_LIMIT, yl);
  endtask

  // Sender runs in bursts; valid only drops between bursts.
  task automatic send_offset(input logic signed [mos_pkg::VAL_W-1:0] dx,
                             input logic signed [mos_pkg::VAL_W-1:0] dy);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{meas_dx: dx, meas_dy: dy};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    smooth_offset(dx, dy);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver stall pattern, periodically switching to a randomly drawn ready mode.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase++;
    if (stall_phase % 300 == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_SPARSE_STALL: out_ready <= ($urandom_range(0, 3) != 0);
      RDY_LONG_STALL: out_ready <= ((stall_phase % 41) >= 30);
      default: out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    mos_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (mean_queue.size() == 0) begin
        report_mismatch("unexpected transaction, smooth_dx", int'(out_data.smooth_dx), 0);
      end else begin
        want = mean_queue.pop_front();
        if (out_data.smooth_dx !== want.smooth_dx)
          report_mismatch("smooth_dx", int'(out_data.smooth_dx), int'(want.smooth_dx));
        if (out_data.smooth_dy !== want.smooth_dy)
          report_mismatch("smooth_dy", int'(out_data.smooth_dy), int'(want.smooth_dy));
        if (out_data.rejected !== want.rejected)
          report_mismatch("rejected", int'(out_data.rejected), int'(want.rejected));
      end
    end
  end

  // Reset limits; magnitudes just inside and just past 5 and 20, both signs.
  // The window is still filling here, so the mean divides by the fill count.
  task automatic test_default_limits();
    send_offset(16'sd0, 16'sd0);
    send_offset(16'sd383, 16'sd1343);
    send_offset(-16'sd383, -16'sd1343);
    send_offset(16'sd384, 16'sd0);
    send_offset(-16'sd384, 16'sd0);
    send_offset(16'sd100, 16'sd1344);
    send_offset(16'sd100, -16'sd1344);
    send_offset(16'sh8000, 16'sd0);
    send_offset(16'sd0, 16'sh8000);
    send_offset(16'sh7fff, 16'sh7fff);
    drain_results();
  endtask

  // Widest and narrowest limits; the most negative input is always rejected.
  task automatic test_limit_extremes();
    set_limits(9'd511, 9'd511);
    send_offset(16'sh7fff, -16'sh7fff);
    send_offset(-16'sh7fff, 16'sh7fff);
    send_offset(16'sh8000, 16'sd0);
    send_offset(16'sd0, 16'sh8000);
    drain_results();
    set_limits(9'd0, 9'd0);
    send_offset(16'sd63, -16'sd63);
    send_offset(16'sd64, 16'sd0);
    send_offset(-16'sd63, 16'sd64);
    drain_results();
  endtask

  // Writes to unassigned indexes must leave both limits alone.
  task automatic test_spare_indexes();
    set_limits(9'd3, 9'd7);
    write_reg(REG_SPARE_A, mos_pkg::LIMIT_W'($urandom_range(0, 511)));
    write_reg(REG_SPARE_B, mos_pkg::LIMIT_W'($urandom_range(0, 511)));
    send_offset(16'sd255, 16'sd511);
    send_offset(16'sd256, 16'sd0);
    send_offset(16'sd0, 16'sd512);
    send_offset(-16'sd255, -16'sd511);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [mos_pkg::LIMIT_W-1:0] xl;
    logic [mos_pkg::LIMIT_W-1:0] yl;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin xl = 9'd0; yl = 9'd0; end
        1: begin xl = 9'd511; yl = 9'd511; end
        2: begin xl = 9'd0; yl = 9'd511; end
        3: begin xl = 9'd511; yl = 9'd0; end
        4: begin xl = mos_pkg::X_LIMIT_RESET; yl = mos_pkg::Y_LIMIT_RESET; end
        default: begin
          xl = ($urandom_range(0, 3) == 0) ? mos_pkg::LIMIT_W'($urandom_range(0, 511))
                                           : mos_pkg::LIMIT_W'($urandom_range(0, 40));
          yl = ($urandom_range(0, 3) == 0) ? mos_pkg::LIMIT_W'($urandom_range(0, 511))
                                           : mos_pkg::LIMIT_W'($urandom_range(0, 40));
        end
      endcase
      set_limits(xl, yl);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_offset(rand_offset(lim_x), rand_offset(lim_y));
        // Hold off once in the middle of a phase until the block is empty.
        if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_limits();
    test_limit_extremes();
    test_spare_indexes();
    test_random_phases();
    drain_results();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
design/mos_pkg.sv
design/mos_ram.sv
design/mos_lane.sv
design/motion_offset_smoother.sv
test/tb_motion_offset_smoother.sv
